@@ rtl/swg_pkg.sv @@
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types, sizes and the quarter-wave sine table for the sine generator.
// ----------------------------------------------------------------------------
package swg_pkg;

  // Table depth must be a power of two; the address is a slice of the phase
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned PHASE_BITS  = 32;
  localparam int unsigned TableAw     = $clog2(TABLE_DEPTH);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AmpW     = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned RomW     = 15;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] TwoDepth  = 64'(2 * TABLE_DEPTH);
  localparam logic [63:0] OneQ30    = 64'd1073741824;
  localparam logic [63:0] HalfQ30   = 64'd536870912;
  localparam logic [63:0] FullScale = 64'd32767;

  // Taylor series divisors (n+1)(n+2) for n = 1, 3, ..., 13
  localparam logic [63:0] TaylorDiv [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgPhaseStep   = 2'd0,
    CfgPhaseOffset = 2'd1,
    CfgAmplitude   = 2'd2,
    CfgSampleCount = 2'd3
  } cfg_reg_e;

  // Running state held in the state memory
  typedef struct packed {
    logic [PHASE_BITS-1:0] acc;
    logic [CountW-1:0]     idx;
  } swg_state_t;

  typedef logic [RomW-1:0] rom_t [TABLE_DEPTH];

  // round(32767 * sin(x)) for x in Q2.30, x in [0, pi/2], truncated products
  function automatic logic [RomW-1:0] fixed_sine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] scaled;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 0; i < 7; i++) begin
      term = ((term * x2) >> 30) / TaylorDiv[i];
      if ((i % 2) == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(OneQ30)) begin
      sum = longint'(OneQ30);
    end
    scaled = (64'(sum) * FullScale + HalfQ30) >> 30;
    return scaled[RomW-1:0];
  endfunction

  // Entry k samples the sine at the middle of its slot
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] x;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      x      = (HalfPiQ30 * (64'(2 * k) + 64'd1)) / TwoDepth;
      tbl[k] = fixed_sine(x);
    end
    return tbl;
  endfunction

endpackage

@@ rtl/swg_quarter_rom.sv @@
// ----------------------------------------------------------------------------
// swg_quarter_rom
// Quarter-wave sine ROM with symmetry folding and a registered read port.
// ----------------------------------------------------------------------------
module swg_quarter_rom (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [swg_pkg::PHASE_BITS-1:0] phase_i,
  output logic [swg_pkg::RomW-1:0]       value_o,
  output logic                           neg_o
);
  import swg_pkg::*;

  localparam rom_t RomTable = build_rom();

  logic [1:0]         quad;
  logic [TableAw-1:0] slot;
  logic [TableAw-1:0] addr;
  logic [RomW-1:0]    value_q;
  logic               neg_q;

  // Fold the quadrant onto the stored quarter wave
  always_comb begin
    quad = phase_i[PHASE_BITS-1 -: 2];
    slot = phase_i[PHASE_BITS-3 -: TableAw];
    addr = quad[0] ? ~slot : slot;
  end

  // Read the table, hold while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= RomTable[addr];
      neg_q   <= quad[1];
    end
  end

  assign value_o = value_q;
  assign neg_o   = neg_q;

endmodule

@@ rtl/sine_wave_generator.sv @@
// ----------------------------------------------------------------------------
// sine_wave_generator
// Direct digital synthesis sine source with amplitude scaling and run marking.
// ----------------------------------------------------------------------------
// One sample item leaves for every tick item taken, and a new tick is taken in
// every clock cycle while the output side is not stalled: the rate is one item
// per cycle. Each tick passes the registered phase add, ROM read and amplitude
// multiply stages. The rate is set by the phase accumulator and sample
// counter, which live in a one-entry state memory read back each cycle with the
// last write forwarded; the sine table is a 1024-entry quarter-wave ROM with a
// registered read. Configuration writes are always ready and take effect for
// ticks accepted after the write; write them only while no tick is in flight.
module sine_wave_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [swg_pkg::SampleW-1:0] sample_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swg_pkg::CfgDataW-1:0] cfg_data_i
);
  import swg_pkg::*;

  localparam logic [31:0] RoundHalf = 32'd32768;

  logic [PHASE_BITS-1:0] phase_step_q;
  logic [PHASE_BITS-1:0] phase_offset_q;
  logic [AmpW-1:0]       amplitude_q;
  logic [CountW-1:0]     sample_count_q;

  swg_state_t state_mem [1];
  swg_state_t rd_q;
  swg_state_t fwd_q;
  logic       fwd_valid_q;
  logic       mem_valid_q;
  swg_state_t cur_state;
  swg_state_t base_state;
  swg_state_t next_state;

  logic                  adv;
  logic                  in_acc;
  logic [PHASE_BITS-1:0] phase;
  logic [CountW:0]       idx_inc;
  logic                  last;

  logic                  v1_q;
  logic [PHASE_BITS-1:0] phase1_q;
  logic                  last1_q;
  logic                  v2_q;
  logic                  last2_q;
  logic [RomW-1:0]       rom_value;
  logic                  rom_neg;

  logic [30:0]           prod;
  logic [31:0]           rounded;
  logic [SampleW-1:0]    mag;
  logic                  out_valid_q;
  logic [SampleW-1:0]    sample_q;
  logic                  last_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= '0;
      phase_offset_q <= '0;
      amplitude_q    <= '1;
      sample_count_q <= CountW'(1024);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgPhaseStep:   phase_step_q   <= PHASE_BITS'(cfg_data_i);
        CfgPhaseOffset: phase_offset_q <= PHASE_BITS'(cfg_data_i);
        CfgAmplitude:   amplitude_q    <= cfg_data_i[AmpW-1:0];
        CfgSampleCount: sample_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished item is held at the output
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  // Pick the current state: forwarded write, stored entry or reset value
  always_comb begin
    if (fwd_valid_q) begin
      cur_state = fwd_q;
    end else if (mem_valid_q) begin
      cur_state = rd_q;
    end else begin
      cur_state = '0;
    end
    base_state = restart_i ? '0 : cur_state;
    phase      = base_state.acc + phase_offset_q;
    idx_inc    = {1'b0, base_state.idx} + (CountW+1)'(1);
    last       = idx_inc >= {1'b0, sample_count_q};
    if (last) begin
      next_state = '0;
    end else begin
      next_state.acc = base_state.acc + phase_step_q;
      next_state.idx = idx_inc[CountW-1:0];
    end
  end

  // State memory: write back on each item, read every cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      state_mem[0] <= next_state;
    end
    rd_q  <= state_mem[0];
    fwd_q <= next_state;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      mem_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= in_acc;
      if (in_acc) begin
        mem_valid_q <= 1'b1;
      end
    end
  end

  // Stage one: output phase and run mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      phase1_q <= phase;
      last1_q  <= last;
    end
  end

  // Stage two: sine table lookup
  swg_quarter_rom u_rom (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (phase1_q),
    .value_o (rom_value),
    .neg_o   (rom_neg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last2_q <= last1_q;
    end
  end

  // Stage three: scale by amplitude, round half away from zero, apply sign
  always_comb begin
    prod    = 31'(rom_value) * 31'(amplitude_q);
    rounded = {1'b0, prod} + RoundHalf;
    mag     = rounded[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_q <= rom_neg ? (~mag + SampleW'(1)) : mag;
      last_q   <= last2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

@@ rtl/swg_checker.sv @@
// ----------------------------------------------------------------------------
// swg_port_props
// Port-level checks for the sine generator, bound to the top level.
// ----------------------------------------------------------------------------
module swg_port_props (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [swg_pkg::SampleW-1:0]  sample_o,
  input logic                         last_o
);

  // The input side only stalls behind a held output item
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output item");

  // With a free output side an accepted tick leaves as a valid sample item
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("sample item missing three cycles after its tick");

  // A held output item keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(sample_o) && $stable(last_o)))
    else $error("stalled output item changed");

endmodule

bind sine_wave_generator swg_port_props u_swg_port_props (.*);
